@@ src/bilinear_image_resize_macros.svh @@
// assertion macros for the bilinear resize block
`ifndef BILINEAR_IMAGE_RESIZE_MACROS_SVH
`define BILINEAR_IMAGE_RESIZE_MACROS_SVH
`ifndef SYNTHESIS
`define BIR_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define BIR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define BIR_ASSERT_IMP(label, pre, post)
`define BIR_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ src/bir_pkg.sv @@
// shared constants and types of the bilinear resize block
`timescale 1ns / 1ps
package bir_pkg;
	localparam int MAX_SIDE_DEF  = 256;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CHANNELS      = 3;
	localparam int CFG_W         = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int PIX_W         = 8 * CHANNELS;
	localparam int RES_W         = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd3;

	localparam logic [CFG_W-1:0] RST_IN_HEIGHT  = 9'd256;
	localparam logic [CFG_W-1:0] RST_IN_WIDTH   = 9'd256;
	localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 9'd224;
	localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 9'd224;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PRODUCE = 1'b1;

	typedef logic [RES_W-1:0] chan_res_t;
endpackage

@@ src/bir_div.sv @@
// restoring divider, one quotient bit per cycle, computes the axis scales
`timescale 1ns / 1ps
module bir_div #(
	parameter int NUM_W = 25,
	parameter int DEN_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// remainder stays below the divisor, so its top bit drops out
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ src/bir_lane.sv @@
// one colour lane: row blends, then column blend, two register stages
`timescale 1ns / 1ps
module bir_lane #(
	parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic [7:0]              tl,
	input  logic [7:0]              tr,
	input  logic [7:0]              bl,
	input  logic [7:0]              br,
	input  logic [FRAC_BITS-1:0]    fx,
	input  logic [FRAC_BITS-1:0]    fy,
	output bir_pkg::chan_res_t      result
);
	localparam int F = FRAC_BITS;

	logic signed [8:0]     d_top;
	logic signed [8:0]     d_bot;
	logic signed [F+9:0]   top_w;
	logic signed [F+9:0]   bot_w;
	logic [F+7:0]          top_s1;
	logic [F+7:0]          bot_s1;
	logic signed [F+8:0]   d_col;
	logic signed [2*F+9:0] v_w;
	bir_pkg::chan_res_t    res_s2;

	always_comb begin
		d_top = $signed({1'b0, tr}) - $signed({1'b0, tl});
		d_bot = $signed({1'b0, br}) - $signed({1'b0, bl});
		top_w = $signed({2'b00, tl, {F{1'b0}}}) + d_top * $signed({1'b0, fx});
		bot_w = $signed({2'b00, bl, {F{1'b0}}}) + d_bot * $signed({1'b0, fx});
		d_col = $signed({1'b0, bot_s1}) - $signed({1'b0, top_s1});
		v_w   = $signed({2'b00, top_s1, {F{1'b0}}}) + d_col * $signed({1'b0, fy});
	end

	// blends lie between their end points, so they are never negative
	always_ff @(posedge clk) begin
		top_s1 <= top_w[F+7:0];
		bot_s1 <= bot_w[F+7:0];
		res_s2 <= v_w[2*F+7:2*F-8];
	end

	assign result = res_s2;
endmodule

@@ src/bir_merge.sv @@
// output register, gathers the lane results into one transaction
`timescale 1ns / 1ps
module bir_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  bir_pkg::chan_res_t                    lane_res [bir_pkg::CHANNELS],
	input  logic                                  last,
	output logic                                  free,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [bir_pkg::CHANNELS*bir_pkg::RES_W-1:0] m_tdata,
	output logic                                  m_tlast
);
	logic                                          valid_q;
	logic [bir_pkg::CHANNELS*bir_pkg::RES_W-1:0]   data_q;
	logic                                          last_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int c = 0; c < bir_pkg::CHANNELS; c++) begin
				data_q[c*bir_pkg::RES_W +: bir_pkg::RES_W] <= lane_res[c];
			end
			last_q <= last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
endmodule

@@ src/bilinear_image_resize.sv @@
// bilinear image resize: a load writes the store as it is accepted, a produce loads the output
// register after map, address, four single-port store reads, two lane stages, merge
// next item accepted in the cycle after the merge, so one produce at a time, held while output stalls
// after reset and after each register write the input is held off while the scale divider
// works out the y scale and then the x scale
// reset clears control state, the store stays unset
`timescale 1ns / 1ps
`include "bilinear_image_resize_macros.svh"
module bilinear_image_resize #(
	parameter int MAX_SIDE  = bir_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [bir_pkg::PIX_W-1:0]                   s_tdata,  // red_in, green_in, blue_in
	input  logic                                        s_tuser,  // operation
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [bir_pkg::CHANNELS*bir_pkg::RES_W-1:0] m_tdata,  // red_out, green_out, blue_out
	output logic                                        m_tlast,
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [bir_pkg::CFG_IDX_W-1:0]               cfg_index,
	input  logic [bir_pkg::CFG_W-1:0]                   cfg_data
);
	localparam int F           = FRAC_BITS;
	localparam int IDX_W       = $clog2(MAX_SIDE);
	localparam int SIDE_W      = IDX_W + 1;
	localparam int ADDR_W      = 2 * IDX_W;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int SC_W        = SIDE_W + F;
	localparam int POS_W       = IDX_W + SC_W;
	localparam int LO_W        = POS_W - F;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIVY = 9'b000000010,
		ST_DIVX = 9'b000000100,
		ST_MAP  = 9'b000001000,
		ST_ADR  = 9'b000010000,
		ST_READ = 9'b000100000,
		ST_BL1  = 9'b001000000,
		ST_BL2  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	function automatic logic [SIDE_W-1:0] eff_size(input logic [bir_pkg::CFG_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = SIDE_W'(v);
		end
		return r;
	endfunction

	state_t                    state_q;
	logic [bir_pkg::CFG_W-1:0] in_h_q, in_w_q, out_h_q, out_w_q;
	logic [SIDE_W-1:0]         ih, iw, oh, ow;
	logic                      stale_q;
	logic [SC_W-1:0]           scale_y_q, scale_x_q;
	logic                      div_start, div_done;
	logic [SC_W-1:0]           div_num, div_quo;
	logic [SIDE_W-1:0]         div_den;

	logic [ADDR_W-1:0]         lp_q;
	logic [2*SIDE_W-1:0]       pix_count;
	logic [2*SIDE_W-1:0]       lp_next;
	logic [IDX_W-1:0]          row_q, col_q, cur_row_q, cur_col_q;
	logic [IDX_W-1:0]          row_e, col_e;
	logic [SIDE_W-1:0]         row_n, col_n;
	logic                      last_q;

	logic [POS_W-1:0]          posy_q, posx_q;
	logic [LO_W-1:0]           ylo_w, xlo_w, yhi_w, xhi_w;
	logic [IDX_W-1:0]          ylo_c, xlo_c, yhi_c, xhi_c;
	logic [ADDR_W-1:0]         base_lo_q, base_hi_q;
	logic [IDX_W-1:0]          xlo_q, xhi_q;
	logic [F-1:0]              fx_q, fy_q;

	logic [2:0]                cnt_q;
	logic [ADDR_W-1:0]         rd_addr;
	logic                      rd_en, wr_en;
	logic [bir_pkg::PIX_W-1:0] rd_q;
	logic [bir_pkg::PIX_W-1:0] px_q [4];
	logic [bir_pkg::PIX_W-1:0] store_q [STORE_DEPTH];

	bir_pkg::chan_res_t        lane_res [bir_pkg::CHANNELS];
	logic                      out_free, out_load;
	logic                      in_acc, cfg_acc;

	assign ih = eff_size(in_h_q);
	assign iw = eff_size(in_w_q);
	assign oh = eff_size(out_h_q);
	assign ow = eff_size(out_w_q);

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_IDLE) && !stale_q;
	assign in_acc    = s_tvalid && s_tready;
	assign wr_en     = in_acc && (s_tuser == bir_pkg::OP_LOAD);
	assign out_load  = (state_q == ST_DONE) && out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_h_q  <= bir_pkg::RST_IN_HEIGHT;
			in_w_q  <= bir_pkg::RST_IN_WIDTH;
			out_h_q <= bir_pkg::RST_OUT_HEIGHT;
			out_w_q <= bir_pkg::RST_OUT_WIDTH;
		end else if (cfg_acc) begin
			case (cfg_index)
				bir_pkg::REG_IN_HEIGHT:  in_h_q  <= cfg_data;
				bir_pkg::REG_IN_WIDTH:   in_w_q  <= cfg_data;
				bir_pkg::REG_OUT_HEIGHT: out_h_q <= cfg_data;
				bir_pkg::REG_OUT_WIDTH:  out_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// scale divider, y axis then x axis
	assign div_start = ((state_q == ST_IDLE) && stale_q) || ((state_q == ST_DIVY) && div_done);
	assign div_num   = (state_q == ST_IDLE) ? {ih, {F{1'b0}}} : {iw, {F{1'b0}}};
	assign div_den   = (state_q == ST_IDLE) ? oh : ow;

	bir_div #(
		.NUM_W (SC_W),
		.DEN_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// output position with wrap for stale coordinates
	always_comb begin
		row_e   = (SIDE_W'(row_q) >= oh) ? '0 : row_q;
		col_e   = (SIDE_W'(col_q) >= ow) ? '0 : col_q;
		row_n   = SIDE_W'(row_e) + 1'b1;
		col_n   = SIDE_W'(col_e) + 1'b1;
		pix_count = ih * iw;
		lp_next   = (2*SIDE_W)'(lp_q) + 1'b1;
	end

	// source coordinates
	always_comb begin
		ylo_w = posy_q[POS_W-1:F];
		xlo_w = posx_q[POS_W-1:F];
		if (ylo_w > LO_W'(ih - 1'b1)) ylo_w = LO_W'(ih - 1'b1);
		if (xlo_w > LO_W'(iw - 1'b1)) xlo_w = LO_W'(iw - 1'b1);
		yhi_w = ylo_w + 1'b1;
		xhi_w = xlo_w + 1'b1;
		if (yhi_w > LO_W'(ih - 1'b1)) yhi_w = LO_W'(ih - 1'b1);
		if (xhi_w > LO_W'(iw - 1'b1)) xhi_w = LO_W'(iw - 1'b1);
		ylo_c = ylo_w[IDX_W-1:0];
		yhi_c = yhi_w[IDX_W-1:0];
		xlo_c = xlo_w[IDX_W-1:0];
		xhi_c = xhi_w[IDX_W-1:0];
	end

	always_comb begin
		case (cnt_q)
			3'd0:    rd_addr = base_lo_q + ADDR_W'(xlo_q);
			3'd1:    rd_addr = base_lo_q + ADDR_W'(xhi_q);
			3'd2:    rd_addr = base_hi_q + ADDR_W'(xlo_q);
			default: rd_addr = base_hi_q + ADDR_W'(xhi_q);
		endcase
		rd_en = (state_q == ST_READ) && (cnt_q < 3'd4);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stale_q <= 1'b1;
			lp_q    <= '0;
			row_q   <= '0;
			col_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (stale_q) begin
						state_q <= ST_DIVY;
					end else if (in_acc) begin
						if (s_tuser == bir_pkg::OP_LOAD) begin
							lp_q <= (lp_next >= pix_count) ? '0 : lp_next[ADDR_W-1:0];
						end else begin
							if (col_n >= ow) begin
								col_q <= '0;
								row_q <= (row_n >= oh) ? '0 : row_n[IDX_W-1:0];
							end else begin
								col_q <= col_n[IDX_W-1:0];
								row_q <= row_e;
							end
							state_q <= ST_MAP;
						end
					end
				end
				ST_DIVY: if (div_done) state_q <= ST_DIVX;
				ST_DIVX: if (div_done) state_q <= ST_IDLE;
				ST_MAP:  state_q <= ST_ADR;
				ST_ADR: begin
					cnt_q   <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4) state_q <= ST_BL1;
				end
				ST_BL1:  state_q <= ST_BL2;
				ST_BL2:  state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			// a write forces the scales to be worked out again
			if (cfg_acc) stale_q <= 1'b1;
			else if ((state_q == ST_IDLE) && stale_q) stale_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVY) && div_done) scale_y_q <= div_quo;
		if ((state_q == ST_DIVX) && div_done) scale_x_q <= div_quo;
		if (in_acc && (s_tuser == bir_pkg::OP_PRODUCE)) begin
			cur_row_q <= row_e;
			cur_col_q <= col_e;
			last_q    <= (SIDE_W'(row_e) == oh - 1'b1) && (SIDE_W'(col_e) == ow - 1'b1);
		end
		if (state_q == ST_MAP) begin
			posy_q <= cur_row_q * scale_y_q;
			posx_q <= cur_col_q * scale_x_q;
		end
		if (state_q == ST_ADR) begin
			base_lo_q <= ADDR_W'(ylo_c * iw);
			base_hi_q <= ADDR_W'(yhi_c * iw);
			xlo_q     <= xlo_c;
			xhi_q     <= xhi_c;
			fx_q      <= posx_q[F-1:0];
			fy_q      <= posy_q[F-1:0];
		end
		if ((state_q == ST_READ) && (cnt_q != 3'd0)) begin
			px_q[2'(cnt_q - 1'b1)] <= rd_q;
		end
	end

	// frame store, single port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[lp_q] <= s_tdata;
		end else if (rd_en) begin
			rd_q <= store_q[rd_addr];
		end
	end

	for (genvar c = 0; c < bir_pkg::CHANNELS; c++) begin : g_lane
		bir_lane #(
			.FRAC_BITS (F)
		) u_lane (
			.clk    (clk),
			.tl     (px_q[0][c*8 +: 8]),
			.tr     (px_q[1][c*8 +: 8]),
			.bl     (px_q[2][c*8 +: 8]),
			.br     (px_q[3][c*8 +: 8]),
			.fx     (fx_q),
			.fy     (fy_q),
			.result (lane_res[c])
		);
	end

	bir_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.lane_res (lane_res),
		.last     (last_q),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`BIR_ASSERT_NEXT(a_cfg_blocks_input, cfg_acc, !s_tready)
	`BIR_ASSERT_IMP(a_merge_only_when_free, out_load, !m_tvalid || m_tready)
	`BIR_ASSERT_NEXT(a_result_held, (state_q == ST_DONE) && !out_free, state_q == ST_DONE)
endmodule
